// ===== src/fhacc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the flow histogram accumulator: item types, codes, defaults and
// the saturating add and cosine helpers. Depends on nothing.
package fhacc_pkg;

   localparam int NUM_WINDOWS_DEF    = 4;
   localparam int NUM_BINS_DEF       = 64;
   localparam int COS_TABLE_BITS_DEF = 10;
   localparam int MAX_BIN_AW         = 10;
   localparam int CSR_AW             = 5;

   localparam logic [1:0] ACT_ACCUM  = 2'd0;
   localparam logic [1:0] ACT_BOUNDS = 2'd1;
   localparam logic [1:0] ACT_READ   = 2'd2;

   localparam logic [2:0] REG_NUM_BINS_USED = 3'd0;
   localparam logic [2:0] REG_INV_BIN_WIDTH = 3'd1;
   localparam logic [2:0] REG_PT_LOW        = 3'd2;
   localparam logic [2:0] REG_PT_HIGH       = 3'd3;
   localparam logic [2:0] REG_INV_EVENTS    = 3'd4;

   localparam logic [6:0]  RST_NUM_BINS_USED = 7'd64;
   localparam logic [15:0] RST_INV_BIN_WIDTH = 16'd2560;
   localparam logic [15:0] RST_PT_LOW        = 16'd102;
   localparam logic [15:0] RST_PT_HIGH       = 16'd512;
   localparam logic [23:0] RST_INV_EVENTS    = 24'hFFFFFF;

   localparam longint unsigned Q28_ONE     = 64'd268435456;
   localparam longint unsigned HALF_PI_Q28 = 64'd421657428;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [15:0] rapidity;
      logic [15:0]        transverse_momentum;
      logic [15:0]        particle_angle;
      logic [15:0]        plane_angle;
      logic [15:0]        weight;
      logic [1:0]         window_index;
      logic [5:0]         bin_index;
      logic signed [15:0] bound_low;
      logic signed [15:0] bound_high;
   } req_item_type;

   typedef struct packed {
      logic [47:0]        bin_weight_sum;
      logic signed [47:0] bin_v1_sum;
      logic signed [47:0] bin_v2_sum;
      logic [31:0]        bin_entries;
      logic [47:0]        window_yield;
      logic signed [47:0] window_v1_sum;
      logic signed [47:0] window_v2_sum;
      logic [31:0]        window_entries;
   } rsp_item_type;

   typedef struct packed {
      logic [6:0]  num_bins_used;
      logic [15:0] inv_bin_width;
      logic [15:0] pt_low;
      logic [15:0] pt_high;
      logic [23:0] inv_events;
   } cfg_type;

   typedef enum logic [1:0] {
      OP_ACCUM  = 2'd0,
      OP_BOUNDS = 2'd1,
      OP_READ   = 2'd2
   } op_kind_type;

   typedef struct packed {
      op_kind_type              kind;
      logic [1:0]               win;
      logic                     bin_ok;
      logic [MAX_BIN_AW-1:0]    addr;
      logic                     in_range;
      logic [27:0]              sw;
      logic signed [15:0]       c1;
      logic signed [15:0]       c2;
      logic signed [15:0]       y;
      logic signed [15:0]       lo;
      logic signed [15:0]       hi;
   } op_entry_type;

   typedef struct packed {
      logic [47:0]        w;
      logic signed [47:0] v1;
      logic signed [47:0] v2;
      logic [31:0]        cnt;
   } bin_rec_type;

   typedef struct packed {
      logic [47:0]        yield;
      logic signed [47:0] v1;
      logic signed [47:0] v2;
      logic [31:0]        cnt;
   } win_tot_type;

   function automatic logic [47:0] add_u48(input logic [47:0] a, input logic [27:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {21'd0, b};
      return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
   endfunction

   function automatic logic signed [47:0] add_s48(input logic signed [47:0] a,
                                                  input logic signed [15:0] b);
      logic [48:0] s;
      s = {a[47], a} + {{33{b[15]}}, b};
      if (s[48] != s[47]) begin
         return s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end
      return s[47:0];
   endfunction

   function automatic logic [31:0] inc_u32(input logic [31:0] a);
      return (a == 32'hFFFF_FFFF) ? a : a + 32'd1;
   endfunction

   function automatic logic [14:0] quarter_cos(input int unsigned r, input int ctb);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint c;
      x  = (longint'(r) * HALF_PI_Q28) >> (ctb - 2);
      x2 = (x * x) >> 28;
      t  = Q28_ONE - x2 / 90;
      t  = Q28_ONE - ((x2 * t) >> 28) / 56;
      t  = Q28_ONE - ((x2 * t) >> 28) / 30;
      t  = Q28_ONE - ((x2 * t) >> 28) / 12;
      c  = longint'(Q28_ONE) - longint'(((x2 * t) >> 28) / 2);
      if (c < 0) c = 0;
      c = (c + 8192) >>> 14;
      if (c > 16384) c = 16384;
      return 15'(c);
   endfunction

endpackage

// ===== src/fhacc_csr.sv =====
`timescale 1ns / 1ps
// Configuration register file behind the APB-style port.
// Depends on fhacc_pkg.
module fhacc_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [fhacc_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready,
   output fhacc_pkg::cfg_type             cfg
);
   import fhacc_pkg::*;

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_bins_used <= RST_NUM_BINS_USED;
         cfg_ff.inv_bin_width <= RST_INV_BIN_WIDTH;
         cfg_ff.pt_low        <= RST_PT_LOW;
         cfg_ff.pt_high       <= RST_PT_HIGH;
         cfg_ff.inv_events    <= RST_INV_EVENTS;
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_NUM_BINS_USED: cfg_ff.num_bins_used <= csr_pwdata[6:0];
            REG_INV_BIN_WIDTH: cfg_ff.inv_bin_width <= csr_pwdata[15:0];
            REG_PT_LOW:        cfg_ff.pt_low        <= csr_pwdata[15:0];
            REG_PT_HIGH:       cfg_ff.pt_high       <= csr_pwdata[15:0];
            REG_INV_EVENTS:    cfg_ff.inv_events    <= csr_pwdata[23:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_NUM_BINS_USED: csr_prdata = {25'd0, cfg_ff.num_bins_used};
         REG_INV_BIN_WIDTH: csr_prdata = {16'd0, cfg_ff.inv_bin_width};
         REG_PT_LOW:        csr_prdata = {16'd0, cfg_ff.pt_low};
         REG_PT_HIGH:       csr_prdata = {16'd0, cfg_ff.pt_high};
         REG_INV_EVENTS:    csr_prdata = {8'd0, cfg_ff.inv_events};
         default:           csr_prdata = 32'd0;
      endcase
   end

endmodule

// ===== src/fhacc_front.sv =====
`timescale 1ns / 1ps
// Front end: classifies each accepted item into a queue entry (scaled weight,
// cosines, pT bin, integrated-range flag). Depends on fhacc_pkg.
module fhacc_front #(
   parameter int NUM_BINS       = fhacc_pkg::NUM_BINS_DEF,
   parameter int COS_TABLE_BITS = fhacc_pkg::COS_TABLE_BITS_DEF
) (
   input  logic                      req_valid,
   input  fhacc_pkg::req_item_type   req_data,
   input  fhacc_pkg::cfg_type        cfg,
   input  logic                      busy,
   input  logic                      q_full,
   output logic                      req_stall,
   output logic                      q_push,
   output fhacc_pkg::op_entry_type   q_din
);
   import fhacc_pkg::*;

   localparam int CTB = COS_TABLE_BITS;
   localparam int QSZ = 1 << (CTB - 2);

   logic [14:0] cos_tab [QSZ+1];

   for (genvar k = 0; k <= QSZ; k++) begin : g_cos
      assign cos_tab[k] = quarter_cos(k, CTB);
   end

   function automatic logic signed [15:0] cos_at(input logic [15:0] a);
      logic [CTB-1:0] kk;
      logic [1:0]     quad;
      logic [CTB-2:0] r;
      logic [CTB-2:0] idx;
      logic [15:0]    v;
      kk   = a[15 -: CTB];
      quad = kk[CTB-1 -: 2];
      r    = {1'b0, kk[CTB-3:0]};
      idx  = quad[0] ? (CTB-1)'(QSZ) - r : r;
      v    = {1'b0, cos_tab[idx]};
      return (quad == 2'd1 || quad == 2'd2) ? -v : v;
   endfunction

   logic [15:0] dphi;
   logic [39:0] prod_w;
   logic [31:0] prod_b;
   logic [15:0] pbin;
   logic [10:0] limit;
   logic        pbin_ok;
   logic        known;

   assign req_stall = busy || q_full;
   assign dphi      = req_data.particle_angle - req_data.plane_angle;
   assign prod_w    = 40'(req_data.weight) * 40'(cfg.inv_events);
   assign prod_b    = 32'(req_data.transverse_momentum) * 32'(cfg.inv_bin_width);
   assign pbin      = prod_b[31:16];
   assign limit     = (11'(cfg.num_bins_used) < 11'(NUM_BINS)) ?
                      11'(cfg.num_bins_used) : 11'(NUM_BINS);
   assign pbin_ok   = 17'(pbin) < 17'(limit);
   assign known     = req_data.action == ACT_ACCUM || req_data.action == ACT_BOUNDS ||
                      req_data.action == ACT_READ;
   assign q_push    = req_valid && !req_stall && known;

   always_comb begin
      q_din.win      = req_data.window_index;
      q_din.in_range = req_data.transverse_momentum >= cfg.pt_low &&
                       req_data.transverse_momentum <= cfg.pt_high;
      q_din.sw       = prod_w[39:12];
      q_din.c1       = cos_at(dphi);
      q_din.c2       = cos_at({dphi[14:0], 1'b0});
      q_din.y        = req_data.rapidity;
      q_din.lo       = req_data.bound_low;
      q_din.hi       = req_data.bound_high;
      unique case (req_data.action)
         ACT_ACCUM: begin
            q_din.kind   = OP_ACCUM;
            q_din.bin_ok = pbin_ok;
            q_din.addr   = pbin[MAX_BIN_AW-1:0];
         end
         ACT_BOUNDS: begin
            q_din.kind   = OP_BOUNDS;
            q_din.bin_ok = 1'b0;
            q_din.addr   = '0;
         end
         default: begin
            q_din.kind   = OP_READ;
            q_din.bin_ok = 11'(req_data.bin_index) < 11'(NUM_BINS);
            q_din.addr   = MAX_BIN_AW'(req_data.bin_index);
         end
      endcase
   end

endmodule

// ===== src/fhacc_queue.sv =====
`timescale 1ns / 1ps
// Two-entry queue between front and back end.
// Depends on fhacc_pkg.
module fhacc_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  fhacc_pkg::op_entry_type  din,
   input  logic                     pop,
   output fhacc_pkg::op_entry_type  dout,
   output logic                     full,
   output logic                     empty
);
   import fhacc_pkg::*;

   op_entry_type slot_ff [2];
   logic         wr_ptr_ff;
   logic         rd_ptr_ff;
   logic [1:0]   cnt_ff;

   assign dout  = slot_ff[rd_ptr_ff];
   assign full  = cnt_ff == 2'd2;
   assign empty = cnt_ff == 2'd0;

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= din;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

// ===== src/fhacc_back.sv =====
`timescale 1ns / 1ps
// Back end: window bounds, per-window bin memories, window totals and the
// result register. Depends on fhacc_pkg.
module fhacc_back #(
   parameter int NUM_WINDOWS = fhacc_pkg::NUM_WINDOWS_DEF,
   parameter int NUM_BINS    = fhacc_pkg::NUM_BINS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_empty,
   input  fhacc_pkg::op_entry_type  q_head,
   output logic                     q_pop,
   output logic                     busy,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output fhacc_pkg::rsp_item_type  rsp_data
);
   import fhacc_pkg::*;

   localparam int WIN_AW = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;
   localparam int BIN_AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_APPLY = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [BIN_AW-1:0]  clr_ff, clr_in;
   op_entry_type       cur_ff;
   logic signed [15:0] lo_ff [NUM_WINDOWS];
   logic signed [15:0] hi_ff [NUM_WINDOWS];
   win_tot_type        tot_ff [NUM_WINDOWS];
   bin_rec_type        rd_ff [NUM_WINDOWS];
   rsp_item_type       rsp_ff;
   logic               rsp_valid_ff;

   logic                    clearing, rd_en, bounds_wr, apply_accum, rsp_free, rsp_load;
   logic                    clr_last;
   logic [4:0]              head_winx, cur_winx;
   logic [WIN_AW-1:0]       head_widx, cur_widx;
   logic                    head_wok, cur_wok;
   logic [NUM_WINDOWS-1:0]  match, we;
   logic [BIN_AW-1:0]       wa, ra;
   bin_rec_type             wd [NUM_WINDOWS];
   bin_rec_type             sel_rec;
   win_tot_type             sel_tot;

   assign clearing    = state_ff == ST_CLEAR;
   assign busy        = clearing;
   assign clr_last    = clr_ff == BIN_AW'(NUM_BINS - 1);
   assign q_pop       = state_ff == ST_IDLE && !q_empty;
   assign rd_en       = q_pop && q_head.kind != OP_BOUNDS;
   assign head_winx   = 5'(q_head.win);
   assign head_widx   = head_winx[WIN_AW-1:0];
   assign head_wok    = head_winx < 5'(NUM_WINDOWS);
   assign bounds_wr   = q_pop && q_head.kind == OP_BOUNDS && head_wok;
   assign cur_winx    = 5'(cur_ff.win);
   assign cur_widx    = cur_winx[WIN_AW-1:0];
   assign cur_wok     = cur_winx < 5'(NUM_WINDOWS);
   assign apply_accum = state_ff == ST_APPLY && cur_ff.kind == OP_ACCUM;
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_load    = state_ff == ST_APPLY && cur_ff.kind == OP_READ && rsp_free;
   assign wa          = clearing ? clr_ff : cur_ff.addr[BIN_AW-1:0];
   assign ra          = q_head.addr[BIN_AW-1:0];
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_ff;

   for (genvar w = 0; w < NUM_WINDOWS; w++) begin : g_win
      bin_rec_type mem [NUM_BINS];

      assign match[w] = lo_ff[w] < cur_ff.y && cur_ff.y <= hi_ff[w];
      assign we[w]    = clearing || (apply_accum && match[w] && cur_ff.bin_ok);

      always_comb begin
         if (clearing) begin
            wd[w] = '0;
         end else begin
            wd[w].w   = add_u48(rd_ff[w].w, cur_ff.sw);
            wd[w].v1  = add_s48(rd_ff[w].v1, cur_ff.c1);
            wd[w].v2  = add_s48(rd_ff[w].v2, cur_ff.c2);
            wd[w].cnt = inc_u32(rd_ff[w].cnt);
         end
      end

      always_ff @(posedge clock) begin
         if (we[w]) mem[wa] <= wd[w];
         if (rd_en) rd_ff[w] <= mem[ra];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            lo_ff[w]  <= '0;
            hi_ff[w]  <= '0;
            tot_ff[w] <= '0;
         end else begin
            if (bounds_wr && head_widx == WIN_AW'(w)) begin
               lo_ff[w] <= q_head.lo;
               hi_ff[w] <= q_head.hi;
            end
            if (apply_accum && match[w]) begin
               tot_ff[w].yield <= add_u48(tot_ff[w].yield, cur_ff.sw);
               if (cur_ff.in_range) begin
                  tot_ff[w].v1  <= add_s48(tot_ff[w].v1, cur_ff.c1);
                  tot_ff[w].v2  <= add_s48(tot_ff[w].v2, cur_ff.c2);
                  tot_ff[w].cnt <= inc_u32(tot_ff[w].cnt);
               end
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (rd_en) state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (cur_ff.kind != OP_READ || rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (rsp_load)      rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) cur_ff <= q_head;
   end

   assign sel_rec = (cur_wok && cur_ff.bin_ok) ? rd_ff[cur_widx] : '0;
   assign sel_tot = cur_wok ? tot_ff[cur_widx] : '0;

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff.bin_weight_sum <= sel_rec.w;
         rsp_ff.bin_v1_sum     <= sel_rec.v1;
         rsp_ff.bin_v2_sum     <= sel_rec.v2;
         rsp_ff.bin_entries    <= sel_rec.cnt;
         rsp_ff.window_yield   <= sel_tot.yield;
         rsp_ff.window_v1_sum  <= sel_tot.v1;
         rsp_ff.window_v2_sum  <= sel_tot.v2;
         rsp_ff.window_entries <= sel_tot.cnt;
      end
   end

endmodule

// ===== src/flow_histogram_accumulator_core.sv =====
`timescale 1ns / 1ps
// Flow histogram accumulator, top level.
// Channels: req_ carries one item (accumulate particle, write window bounds,
// or read sums); rsp_ returns one item for each read. Both use valid/stall;
// an item moves when valid is high and stall is low.
// Configuration: APB-style csr_ port, register i at byte address 4*i; the user
// must write it only while the block is idle; the block does not enforce this.
// Back end: a bounds write completes in the idle state; an accumulate or read
// reads the per-window bin memory in idle, then does the read-modify-write or
// loads the result register in apply, and only then takes the next item.
// The front end classifies items into a two-entry queue, so it keeps taking
// items while the back end works or the result waits.
// Reset: all registers return to their defaults, bounds and totals clear,
// and a clearing pass over all NUM_BINS addresses zeroes the bin memories;
// req_stall stays high until it is done.
// When the receiver stalls, the result holds in its register, the back end
// waits and the queue fills; then req_stall rises.
module flow_histogram_accumulator_core #(
   parameter int NUM_WINDOWS    = fhacc_pkg::NUM_WINDOWS_DEF,
   parameter int NUM_BINS       = fhacc_pkg::NUM_BINS_DEF,
   parameter int COS_TABLE_BITS = fhacc_pkg::COS_TABLE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  fhacc_pkg::req_item_type        req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output fhacc_pkg::rsp_item_type        rsp_data,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [fhacc_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import fhacc_pkg::*;

   cfg_type      cfg;
   logic         busy, q_full, q_empty, q_push, q_pop;
   op_entry_type q_din, q_head;

   fhacc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fhacc_front #(
      .NUM_BINS       (NUM_BINS),
      .COS_TABLE_BITS (COS_TABLE_BITS)
   ) u_front (
      .req_valid (req_valid),
      .req_data  (req_data),
      .cfg       (cfg),
      .busy      (busy),
      .q_full    (q_full),
      .req_stall (req_stall),
      .q_push    (q_push),
      .q_din     (q_din)
   );

   fhacc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_din),
      .pop   (q_pop),
      .dout  (q_head),
      .full  (q_full),
      .empty (q_empty)
   );

   fhacc_back #(
      .NUM_WINDOWS (NUM_WINDOWS),
      .NUM_BINS    (NUM_BINS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for flow_histogram_accumulator_core: directed and random items,
// with a built-in predictor checked against each read result under random idling.
// Depends on fhacc_pkg and the core RTL.
module testbench;
   import fhacc_pkg::*;

   localparam int NWIN = 4;
   localparam int NBIN = 64;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam longint unsigned U48_MAX = 64'hFFFF_FFFF_FFFF;
   localparam longint S48_MAX = 64'sh7FFF_FFFF_FFFF;
   localparam longint S48_MIN = -64'sh8000_0000_0000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_item_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_item_type rsp_data;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   flow_histogram_accumulator_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // predictor state
   int               cos_lut [1024];
   cfg_type          model_cfg;
   int               win_lo [NWIN];
   int               win_hi [NWIN];
   longint unsigned  bin_w [NWIN*NBIN];
   longint           bin_c1 [NWIN*NBIN];
   longint           bin_c2 [NWIN*NBIN];
   longint unsigned  bin_n [NWIN*NBIN];
   longint unsigned  tot_yield [NWIN];
   longint           tot_c1 [NWIN];
   longint           tot_c2 [NWIN];
   longint unsigned  tot_n [NWIN];

   rsp_item_type pending_sums[$];
   int errors;
   int items_sent;
   int sums_checked;
   int idle_cycles;
   bit no_gaps;
   bit hold_long;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int poly_cos(input longint unsigned r);
      longint unsigned x, x2, t;
      longint c;
      x  = (r * HALF_PI_Q28) >> 8;
      x2 = (x * x) >> 28;
      t  = Q28_ONE - x2 / 90;
      t  = Q28_ONE - ((x2 * t) >> 28) / 56;
      t  = Q28_ONE - ((x2 * t) >> 28) / 30;
      t  = Q28_ONE - ((x2 * t) >> 28) / 12;
      c  = longint'(Q28_ONE) - longint'(((x2 * t) >> 28) / 2);
      if (c < 0) c = 0;
      c = (c + 8192) >>> 14;
      if (c > 16384) c = 16384;
      return int'(c);
   endfunction

   function automatic int angle_cos(input logic [15:0] a);
      int k;
      k = a >> 6;
      case ((k >> 8) & 3)
         0: return poly_cos(k & 255);
         1: return -poly_cos(256 - (k & 255));
         2: return -poly_cos(k & 255);
         default: return poly_cos(256 - (k & 255));
      endcase
   endfunction

   function automatic longint unsigned sat_u48(input longint unsigned a, input longint unsigned b);
      longint unsigned s;
      s = a + b;
      return (s > U48_MAX) ? U48_MAX : s;
   endfunction

   function automatic longint sat_s48(input longint a, input longint b);
      longint s;
      s = a + b;
      if (s > S48_MAX) return S48_MAX;
      if (s < S48_MIN) return S48_MIN;
      return s;
   endfunction

   function automatic longint unsigned bump_u32(input longint unsigned a);
      return (a >= 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : a + 1;
   endfunction

   task automatic clear_model();
      model_cfg = '{RST_NUM_BINS_USED, RST_INV_BIN_WIDTH, RST_PT_LOW, RST_PT_HIGH,
                    RST_INV_EVENTS};
      for (int i = 0; i < NWIN; i++) begin
         win_lo[i] = 0;
         win_hi[i] = 0;
         tot_yield[i] = 0;
         tot_c1[i] = 0;
         tot_c2[i] = 0;
         tot_n[i] = 0;
      end
      for (int i = 0; i < NWIN*NBIN; i++) begin
         bin_w[i] = 0;
         bin_c1[i] = 0;
         bin_c2[i] = 0;
         bin_n[i] = 0;
      end
      for (int i = 0; i < 1024; i++) cos_lut[i] = angle_cos(16'(i << 6));
   endtask

   task automatic predict_item(input req_item_type it);
      logic [15:0] dphi;
      longint c1, c2;
      longint unsigned sw, pbin, lim;
      bit in_range;
      int y, a;
      rsp_item_type res;
      case (it.action)
         ACT_ACCUM: begin
            y = it.rapidity;
            dphi = it.particle_angle - it.plane_angle;
            c1 = cos_lut[dphi >> 6];
            c2 = cos_lut[16'(dphi << 1) >> 6];
            sw = (longint'(it.weight) * longint'(model_cfg.inv_events)) >> 12;
            pbin = (longint'(it.transverse_momentum) * longint'(model_cfg.inv_bin_width)) >> 16;
            lim = (model_cfg.num_bins_used < NBIN) ? model_cfg.num_bins_used : NBIN;
            in_range = it.transverse_momentum >= model_cfg.pt_low &&
                       it.transverse_momentum <= model_cfg.pt_high;
            for (int w = 0; w < NWIN; w++) begin
               if (win_lo[w] < y && y <= win_hi[w]) begin
                  if (pbin < lim) begin
                     a = w * NBIN + int'(pbin);
                     bin_w[a] = sat_u48(bin_w[a], sw);
                     bin_c1[a] = sat_s48(bin_c1[a], c1);
                     bin_c2[a] = sat_s48(bin_c2[a], c2);
                     bin_n[a] = bump_u32(bin_n[a]);
                  end
                  if (in_range) begin
                     tot_c1[w] = sat_s48(tot_c1[w], c1);
                     tot_c2[w] = sat_s48(tot_c2[w], c2);
                     tot_n[w] = bump_u32(tot_n[w]);
                  end
                  tot_yield[w] = sat_u48(tot_yield[w], sw);
               end
            end
         end
         ACT_BOUNDS: begin
            win_lo[it.window_index] = it.bound_low;
            win_hi[it.window_index] = it.bound_high;
         end
         ACT_READ: begin
            a = it.window_index * NBIN + it.bin_index;
            res.bin_weight_sum = bin_w[a][47:0];
            res.bin_v1_sum     = bin_c1[a][47:0];
            res.bin_v2_sum     = bin_c2[a][47:0];
            res.bin_entries    = bin_n[a][31:0];
            res.window_yield   = tot_yield[it.window_index][47:0];
            res.window_v1_sum  = tot_c1[it.window_index][47:0];
            res.window_v2_sum  = tot_c2[it.window_index][47:0];
            res.window_entries = tot_n[it.window_index][31:0];
            pending_sums.push_back(res);
         end
         default: ;
      endcase
   endtask

   task automatic send_item(input req_item_type it);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_item(it);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_sums.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_AW'(idx) << 2;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_NUM_BINS_USED: model_cfg.num_bins_used = value[6:0];
         REG_INV_BIN_WIDTH: model_cfg.inv_bin_width = value[15:0];
         REG_PT_LOW:        model_cfg.pt_low = value[15:0];
         REG_PT_HIGH:       model_cfg.pt_high = value[15:0];
         REG_INV_EVENTS:    model_cfg.inv_events = value[23:0];
         default: ;
      endcase
   endtask

   function automatic req_item_type make_item(input logic [1:0] act);
      req_item_type it;
      it.action              = act;
      it.rapidity            = 16'($urandom);
      it.transverse_momentum = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
      it.particle_angle      = 16'($urandom);
      it.plane_angle         = 16'($urandom);
      it.weight              = 16'($urandom);
      it.window_index        = 2'($urandom);
      it.bin_index           = ($urandom_range(0, 1) == 0) ? 6'($urandom) : 6'($urandom_range(0, 12));
      it.bound_low           = ($urandom_range(0, 7) == 0) ? 16'($urandom) :
                               -16'sd1 * 16'($urandom_range(0, 20000));
      it.bound_high          = ($urandom_range(0, 7) == 0) ? 16'($urandom) :
                               16'($urandom_range(0, 20000));
      return it;
   endfunction

   function automatic req_item_type random_item();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 68) return make_item(ACT_ACCUM);
      if (pick < 78) return make_item(ACT_BOUNDS);
      if (pick < 96) return make_item(ACT_READ);
      return make_item(2'd3);
   endfunction

   task automatic run_random(input int count);
      repeat (count) send_item(random_item());
   endtask

   task automatic test_directed();
      req_item_type it;
      it = make_item(ACT_BOUNDS);
      it.window_index = 0; it.bound_low = -16'sd32768; it.bound_high = 16'sd32767;
      send_item(it);
      it.window_index = 1; it.bound_low = -16'sd4096; it.bound_high = 16'sd4096;
      send_item(it);
      it.window_index = 2; it.bound_low = 16'sd100; it.bound_high = 16'sd100;
      send_item(it);
      it.window_index = 3; it.bound_low = 16'sd0; it.bound_high = 16'sd8192;
      send_item(it);
      it = make_item(ACT_ACCUM);
      it.rapidity = 16'sd32767; it.transverse_momentum = 16'hFFFF; it.weight = 16'hFFFF;
      it.particle_angle = 16'h0000; it.plane_angle = 16'h0000;
      send_item(it);
      it.rapidity = 16'sd100; it.transverse_momentum = 16'd0; it.weight = 16'd0;
      it.particle_angle = 16'h4000; it.plane_angle = 16'hFFFF;
      send_item(it);
      it.rapidity = -16'sd32768; it.transverse_momentum = 16'd200; it.weight = 16'h1000;
      it.particle_angle = 16'h8000; it.plane_angle = 16'h0040;
      send_item(it);
      it.rapidity = 16'sd4096; it.transverse_momentum = 16'd512; it.weight = 16'h8000;
      it.particle_angle = 16'hC000; it.plane_angle = 16'h4000;
      send_item(it);
      it.transverse_momentum = 16'd102; it.particle_angle = 16'hFFFF; it.plane_angle = 16'h0;
      send_item(it);
      it = make_item(2'd3);
      send_item(it);
      for (int w = 0; w < NWIN; w++) begin
         it = make_item(ACT_READ);
         it.window_index = 2'(w);
         it.bin_index = (w == 0) ? 6'd63 : 6'd0;
         send_item(it);
      end
      it = make_item(ACT_READ);
      it.window_index = 1; it.bin_index = 6'd1;
      send_item(it);
      drain();
   endtask

   task automatic test_config_sweep();
      logic [31:0] settings [6][5];
      settings = '{
         '{32'd64, 32'd2560, 32'd102, 32'd512, 32'hFFFFFF},
         '{32'd1, 32'd65535, 32'd0, 32'd65535, 32'd0},
         '{32'd0, 32'd0, 32'd600, 32'd100, 32'd1},
         '{32'd127, 32'd256, 32'd65535, 32'd65535, 32'h800000},
         '{32'd13, 32'd5000, 32'd300, 32'd1500, 32'hFFFFFF},
         '{32'd64, 32'd1024, 32'd0, 32'd0, 32'd4096}
      };
      for (int p = 0; p < 6; p++) begin
         write_reg(REG_NUM_BINS_USED, settings[p][0]);
         write_reg(REG_INV_BIN_WIDTH, settings[p][1]);
         write_reg(REG_PT_LOW, settings[p][2]);
         write_reg(REG_PT_HIGH, settings[p][3]);
         write_reg(REG_INV_EVENTS, settings[p][4]);
         no_gaps = (p == 4);
         run_random(230);
         drain();
      end
      no_gaps = 1'b0;
   endtask

   task automatic test_backpressure();
      req_item_type it;
      hold_long = 1'b1;
      no_gaps = 1'b1;
      for (int i = 0; i < 60; i++) begin
         it = make_item((i % 3 == 0) ? ACT_READ : ACT_ACCUM);
         send_item(it);
      end
      no_gaps = 1'b0;
      drain();
      run_random(200);
      drain();
   endtask

   // receiver: random stall before each item, with one long hold on request
   initial begin
      int hold;
      rsp_stall = 1'b1;
      @(negedge clock);
      forever begin
         hold = $urandom_range(0, 12);
         if ($urandom_range(0, 3) == 0) hold = 0;
         if (hold_long) begin
            hold = 300;
            hold_long = 1'b0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_sums.size() == 0) begin
            $error("unexpected result item");
            errors++;
         end else begin
            want = pending_sums.pop_front();
            sums_checked++;
            if (rsp_data.bin_weight_sum !== want.bin_weight_sum) begin
               $error("bin_weight_sum exp %0h got %0h", want.bin_weight_sum, rsp_data.bin_weight_sum);
               errors++;
            end
            if (rsp_data.bin_v1_sum !== want.bin_v1_sum) begin
               $error("bin_v1_sum exp %0d got %0d", want.bin_v1_sum, rsp_data.bin_v1_sum);
               errors++;
            end
            if (rsp_data.bin_v2_sum !== want.bin_v2_sum) begin
               $error("bin_v2_sum exp %0d got %0d", want.bin_v2_sum, rsp_data.bin_v2_sum);
               errors++;
            end
            if (rsp_data.bin_entries !== want.bin_entries) begin
               $error("bin_entries exp %0d got %0d", want.bin_entries, rsp_data.bin_entries);
               errors++;
            end
            if (rsp_data.window_yield !== want.window_yield) begin
               $error("window_yield exp %0h got %0h", want.window_yield, rsp_data.window_yield);
               errors++;
            end
            if (rsp_data.window_v1_sum !== want.window_v1_sum) begin
               $error("window_v1_sum exp %0d got %0d", want.window_v1_sum, rsp_data.window_v1_sum);
               errors++;
            end
            if (rsp_data.window_v2_sum !== want.window_v2_sum) begin
               $error("window_v2_sum exp %0d got %0d", want.window_v2_sum, rsp_data.window_v2_sum);
               errors++;
            end
            if (rsp_data.window_entries !== want.window_entries) begin
               $error("window_entries exp %0d got %0d", want.window_entries,
                      rsp_data.window_entries);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      errors = 0;
      items_sent = 0;
      sums_checked = 0;
      idle_cycles = 0;
      no_gaps = 1'b0;
      hold_long = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      clear_model();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_config_sweep();
      test_backpressure();
      drain();
      $display("covered %0d items and %0d checked reads over six register settings,",
               items_sent, sums_checked);
      $display("with random idling on both sides and a long result-side hold");
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== flow_histogram_accumulator_core.f =====
src/fhacc_pkg.sv
src/fhacc_csr.sv
src/fhacc_front.sv
src/fhacc_queue.sv
src/fhacc_back.sv
src/flow_histogram_accumulator_core.sv
dv/testbench.sv
